FILE: rtl/deq_pkg.sv
package deq_pkg;

   // Field widths of the request and response transfers
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_USER_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

FILE: rtl/deq_ram.sv
module deq_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the read word until the next read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/double_ended_queue_core.sv
// Double-ended queue of VALUE_WIDTH-bit values held in a circular block RAM of DEPTH entries,
// tracked by a front index and a fill count in flip-flops. Each request transfer carries a
// command in req_tuser (push front, push back, pop front, pop back) and a push value in
// req_tdata; each one yields exactly one response transfer with the popped value (zero for
// pushes and rejected commands), a status (ok, pop on empty, push on full) in rsp_tuser, the
// count after the step and an empty flag. Rejected commands leave the queue untouched. The
// block takes one request per cycle while req_tready is high; a response passes through the
// registered read of the RAM and then the output register. The index and count
// update at acceptance, so a pop straight after a push to the same entry reads the new value.
// req_tready drops only while a response is stalled at the output with another behind it. The
// store needs no clearing: an entry is only read after it was written.
module double_ended_queue_core #(
   parameter int unsigned DEPTH       = 64,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [deq_pkg::REQ_DATA_W-1:0]  req_tdata,   // [31:0] push_value
   input  logic [deq_pkg::REQ_USER_W-1:0]  req_tuser,   // [1:0] command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [deq_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] popped_value,
                                                        // [38:32] entry_count, [39] is_empty
   output logic [deq_pkg::RSP_USER_W-1:0]  rsp_tuser    // [1:0] status
);

   import deq_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = AW + 1;

   // queue state
   logic [AW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;

   // read stage: command accepted, RAM word on its way
   logic             pend_ff, pend_in;
   logic             pop_ok_ff;
   status_type       status_ff;
   logic [CW-1:0]    cnt_snap_ff;

   // output register
   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   status_type       rsp_status_ff;

   logic             accept, out_free, advance;
   cmd_type          cmd;
   logic             full, empty;
   logic [AW-1:0]    front_dec, front_inc;
   logic [SW-1:0]    back_sum, tail_sum;
   logic [AW-1:0]    back_idx, tail_idx;
   logic             wr_en, rd_en, op_ok;
   logic [AW-1:0]    wr_addr, rd_addr;
   status_type       status_in;
   logic [VALUE_WIDTH+VALUE_W-1:0] push_ext;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic [VALUE_WIDTH+VALUE_W-1:0] pop_ext;
   logic [CW+COUNT_W-1:0] cnt_ext;
   logic [VALUE_W-1:0] popped;

   function automatic logic [VALUE_W-1:0] pop_okay_mask(input logic ok,
                                                        input logic [VALUE_W-1:0] v);
      pop_okay_mask = ok ? v : '0;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign cmd   = cmd_type'(req_tuser[CMD_W-1:0]);
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // circular index arithmetic; sums stay below twice the depth
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign back_sum  = SW'(front_ff) + SW'(count_ff);
   assign tail_sum  = back_sum - 1'b1;
   assign back_idx  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
   assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

   assign push_ext = {{VALUE_WIDTH{1'b0}}, req_tdata[VALUE_W-1:0]};

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = front_ff;
      rd_addr   = front_ff;
      op_ok     = 1'b0;
      status_in = ST_OK;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               front_in = front_dec;
               wr_addr  = front_dec;
               wr_en    = accept;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_addr  = back_idx;
               wr_en    = accept;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_addr  = front_ff;
               rd_en    = accept;
               op_ok    = 1'b1;
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_addr  = tail_idx;
               rd_en    = accept;
               op_ok    = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   deq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (VALUE_WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_ext[VALUE_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // fit the stored word and the count to their response fields
   assign pop_ext = {{VALUE_W{1'b0}}, rd_data};
   assign popped  = pop_okay_mask(pop_ok_ff, pop_ext[VALUE_W-1:0]);
   assign cnt_ext = {{COUNT_W{1'b0}}, cnt_snap_ff};

   assign pend_in = accept || (pend_ff && !out_free);

   // queue state advances at acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // read stage: hold the command's outcome while the RAM word arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ok_ff   <= op_ok;
         status_ff   <= status_in;
         cnt_snap_ff <= count_in;
      end
   end

   // output register: load on advance, drop valid once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff   <= {(cnt_snap_ff == '0), cnt_ext[COUNT_W-1:0], popped};
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: rtl/deq_checker.sv
module deq_checker #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [deq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [deq_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [deq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [deq_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   import deq_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata == req_tdata);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // empty flag agrees with the reported count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39] == (rsp_tdata[38:32] == '0) || DEPTH > 127))
      else $error("empty flag disagrees with count");

   // a pop on empty returns nothing and leaves the queue empty
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |->
         rsp_tdata[31:0] == '0 && rsp_tdata[39])
      else $error("bad response to pop on empty");

   // a rejected push returns nothing and reports a full queue
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |->
         rsp_tdata[31:0] == '0 && rsp_tdata[38:32] == FULL_CNT && !rsp_tdata[39])
      else $error("bad response to push on full");

   // no response appears without an accepted request behind it, unless one was already valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      !$past(req_seen, 2) && !$past(rsp_tvalid) |-> !rsp_tvalid)
      else $error("response without a request");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/deque_scoreboard.sv
`timescale 1ns / 100ps

// Watches both channels of the deque, keeps a shadow copy of the circular
// store and compares every response transfer with the oldest prediction.
module deque_scoreboard
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [31:0] push_value
   input  logic [REQ_USER_W-1:0]  req_tuser,   // [1:0] command
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] popped_value,
                                               // [38:32] entry_count, [39] is_empty
   input  logic [RSP_USER_W-1:0]  rsp_tuser,   // [1:0] status
   output int                     fail_count,
   output int                     outstanding
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   typedef struct packed {
      logic [VALUE_W-1:0] popped;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               empty;
   } deque_result;

   logic [VALUE_W-1:0] shadow_store [DEPTH];
   logic [IDX_W-1:0]   shadow_head;
   logic [COUNT_W-1:0] shadow_held;
   deque_result        owed_results [$];
   int                 mismatches;

   // Apply one command to the shadow deque and return its response.
   function automatic deque_result deque_step(cmd_type cmd, logic [VALUE_W-1:0] value);
      deque_result      r;
      logic [IDX_W-1:0] slot;
      r.popped = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (shadow_held == COUNT_W'(DEPTH)) begin
               r.status = ST_FULL;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  shadow_head = shadow_head - 1'b1;
                  slot        = shadow_head;
               end else begin
                  slot = IDX_W'(shadow_head + shadow_held);
               end
               shadow_store[slot] = value;
               shadow_held        = shadow_held + 1'b1;
            end
         end
         default: begin
            if (shadow_held == '0) begin
               r.status = ST_EMPTY;
            end else begin
               if (cmd == CMD_POP_FRONT) begin
                  slot        = shadow_head;
                  shadow_head = shadow_head + 1'b1;
               end else begin
                  slot = IDX_W'(shadow_head + shadow_held - 1'b1);
               end
               r.popped    = shadow_store[slot];
               shadow_held = shadow_held - 1'b1;
            end
         end
      endcase
      r.count = shadow_held;
      r.empty = (shadow_held == '0);
      return r;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
      mismatches  = 0;
      shadow_head = '0;
      shadow_held = '0;
   end

   always @(posedge clock) begin
      deque_result want;
      deque_result got;
      if (reset) begin
         shadow_head = '0;
         shadow_held = '0;
         owed_results.delete();
      end else begin
         // check the response first: it always belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got.popped = rsp_tdata[31:0];
            got.count  = rsp_tdata[38:32];
            got.empty  = rsp_tdata[39];
            got.status = status_type'(rsp_tuser);
            if (owed_results.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("%0t: unexpected response: value %h status %0d count %0d empty %0b",
                           $realtime, got.popped, got.status, got.count, got.empty);
            end else begin
               want = owed_results.pop_front();
               if (got.popped !== want.popped || got.status !== want.status ||
                   got.count !== want.count || got.empty !== want.empty) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch (expected/actual): value %h/%h status %0d/%0d",
                              $realtime, want.popped, got.popped, want.status, got.status);
                     $display("   count %0d/%0d empty %0b/%0b",
                              want.count, got.count, want.empty, got.empty);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            owed_results.push_back(deque_step(cmd_type'(req_tuser), req_tdata[VALUE_W-1:0]));
      end
      fail_count  <= mismatches;
      outstanding <= owed_results.size();
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import deq_pkg::*;

   localparam int LIMIT      = 200000;  // cycles before the run is abandoned
   localparam int RAND_ITEMS = 700;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [31:0] push_value
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [31:0] popped_value,
                                             // [38:32] entry_count, [39] is_empty
   logic [RSP_USER_W-1:0] rsp_tuser;         // [1:0] status

   int fail_count;
   int outstanding;
   int cycles     = 0;
   int burst_left = 0;

   // receiver state: stall pattern and the long hold-off
   int unsigned rx_cycle  = 0;
   int unsigned rx_mode   = 0;
   int unsigned hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue_core #(
      .DEPTH      (64),
      .VALUE_WIDTH(32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   deque_scoreboard #(.DEPTH(64)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   // Abandon the run if it hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("[double_ended_queue_core] ERROR");
         $finish;
      end
   end

   // Receiver: pick a new stall pattern whenever the low byte of rx_cycle is zero; when rx_cycle
   // % 1000 is 150, hold off for a long stretch so the core fills up and drops req_tready.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[7:0] == 8'd0)
         rx_mode <= $urandom_range(0, 3);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (rx_cycle % 1000 == 150) begin
         rsp_tready <= 1'b0;
         hold_left  <= 120;
      end else begin
         case (rx_mode)
            0:       rsp_tready <= 1'b1;                        // no stalls at all
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= (rx_cycle[2:0] < 3'd5);       // fixed duty pattern
            default: rsp_tready <= $urandom_range(0, 1);
         endcase
      end
   end

   // Mostly random words, now and then an extreme.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Offer one transfer and hold it until accepted. Called just after a rising edge.
   task automatic offer_command(input cmd_type cmd, input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         // drop valid for a gap only when the gap is real
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
   endtask

   initial begin
      int      sent;
      int      phase_len;
      int      push_pct;
      cmd_type cmd;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: pops on empty, extremes at both ends, emptying pops from either end
      offer_command(CMD_POP_FRONT, $urandom);
      offer_command(CMD_POP_BACK, $urandom);
      offer_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
      offer_command(CMD_PUSH_FRONT, 32'h8000_0000);
      offer_command(CMD_PUSH_BACK, 32'hFFFF_FFFF);
      offer_command(CMD_PUSH_FRONT, 32'h0000_0000);
      offer_command(CMD_POP_BACK, 32'hFFFF_FFFF);
      offer_command(CMD_POP_FRONT, 32'h0000_0000);
      offer_command(CMD_POP_FRONT, $urandom);
      offer_command(CMD_POP_BACK, $urandom);
      offer_command(CMD_POP_BACK, $urandom);
      offer_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
      offer_command(CMD_PUSH_BACK, 32'h5555_5555);
      offer_command(CMD_POP_FRONT, $urandom);
      offer_command(CMD_POP_FRONT, $urandom);
      offer_command(CMD_POP_FRONT, $urandom);
      offer_command(CMD_PUSH_BACK, 32'h0000_0001);
      offer_command(CMD_POP_BACK, $urandom);
      offer_command(CMD_PUSH_FRONT, 32'h1234_5678);
      offer_command(CMD_POP_BACK, $urandom);

      // random: phases that fill (reaching push on full), drain (reaching pop on
      // empty) or wander around the middle
      sent = 0;
      while (sent < RAND_ITEMS) begin
         phase_len = $urandom_range(40, 120);
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(1, 100) <= push_pct)
               cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else
               cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            offer_command(cmd, pick_value());
            sent = sent + 1;
         end
      end
      req_tvalid <= 1'b0;

      // drain, then allow for stray responses
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("[double_ended_queue_core] OK");
      else
         $display("[double_ended_queue_core] ERROR");
      $finish;
   end

endmodule
